[sv/deq_pkg.sv]
// Shared constants, command and status codes, and the cell control word of the deque.
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [2:0] CMD_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             shift_back;
    logic             shift_front;
    logic             write_back;
    logic [IDX_W-1:0] back_idx;
  } cell_ctrl_t;

endpackage

[sv/deq_cell.sv]
// One storage cell of the deque row, loading from either neighbor or from the pushed word.
module deq_cell (
  input  logic                              clk,
  input  deq_pkg::cell_ctrl_t               ctrl,
  input  logic [deq_pkg::IDX_W-1:0]         idx,
  input  logic signed [deq_pkg::WORD_W-1:0] value,
  input  logic signed [deq_pkg::WORD_W-1:0] from_front,
  input  logic signed [deq_pkg::WORD_W-1:0] from_back,
  output logic signed [deq_pkg::WORD_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctrl.shift_back) begin
      q <= from_front;
    end else if (ctrl.shift_front) begin
      q <= from_back;
    end else if (ctrl.write_back && (ctrl.back_idx == idx)) begin
      q <= value;
    end
  end

endmodule

[sv/double_ended_queue.sv]
// Top level of the bounded double-ended queue built as a shifting row of cells.
// The queue accepts one command in every clock cycle, busy stays low, and the result word
// appears on the result ports with done high in the cycle after the command is taken;
// the result is registered together with the update of the cell row and the fill count. The front
// word always sits in the first cell, so pushes and pops at the front shift the whole row by
// one place, while work at the back touches only the cell that the fill count selects. The
// receiver cannot stall: each result is shown for one cycle only and must be taken then.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        command,
  input  logic signed [deq_pkg::WORD_W-1:0] value,
  output logic                              done,
  output logic signed [deq_pkg::WORD_W-1:0] data,
  output logic [1:0]                        status,
  output logic [deq_pkg::CNT_W-1:0]         occupancy,
  output logic                              is_empty,
  output logic                              is_full
);

  logic [deq_pkg::CNT_W-1:0]         count;
  logic [deq_pkg::CNT_W-1:0]         count_next;
  logic                              accept;
  logic                              empty;
  logic                              full;
  logic [deq_pkg::IDX_W-1:0]         last_idx;
  logic signed [deq_pkg::WORD_W-1:0] data_next;
  logic [1:0]                        status_next;
  deq_pkg::cell_ctrl_t               ctrl;
  logic signed [deq_pkg::WORD_W-1:0] cell_q     [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] from_front [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] from_back  [deq_pkg::DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign empty    = (count == '0);
  assign full     = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign last_idx = deq_pkg::IDX_W'(count - deq_pkg::CNT_W'(1));

  always_comb begin
    ctrl.shift_back  = 1'b0;
    ctrl.shift_front = 1'b0;
    ctrl.write_back  = 1'b0;
    ctrl.back_idx    = deq_pkg::IDX_W'(count);
    count_next       = count;
    data_next        = '0;
    status_next      = deq_pkg::ST_OK;
    if (accept) begin
      case (command)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = deq_pkg::ST_FULL;
          end else begin
            ctrl.shift_back = 1'b1;
            count_next      = count + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_next = deq_pkg::ST_FULL;
          end else begin
            ctrl.write_back = 1'b1;
            count_next      = count + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            data_next        = cell_q[0];
            ctrl.shift_front = 1'b1;
            count_next       = count - deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            data_next  = cell_q[last_idx];
            count_next = count - deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::CMD_PEEK_FRONT: begin
          if (empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            data_next = cell_q[0];
          end
        end
        deq_pkg::CMD_PEEK_BACK: begin
          if (empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            data_next = cell_q[last_idx];
          end
        end
        deq_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign from_front[i] = value;
    end else begin : g_inner
      assign from_front[i] = cell_q[i-1];
    end
    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign from_back[i] = '0;
    end else begin : g_body
      assign from_back[i] = cell_q[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (deq_pkg::IDX_W'(i)),
      .value      (value),
      .from_front (from_front[i]),
      .from_back  (from_back[i]),
      .q          (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    data      <= data_next;
    status    <= status_next;
    occupancy <= count_next;
    is_empty  <= (count_next == '0);
    is_full   <= (count_next == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("command accepted without a result in the next cycle");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= deq_pkg::CNT_W'(deq_pkg::DEPTH)))
    else $error("occupancy exceeds the queue depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == deq_pkg::ST_FULL)) |-> (is_full && (data == '0)))
    else $error("full status reported on a queue that is not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == deq_pkg::ST_EMPTY)) |-> (is_empty && (data == '0)))
    else $error("empty status reported on a queue that is not empty");
`endif

endmodule
